// ===== design/edm_pkg.sv =====
// Shared types and codes for the edge debounce monitor.
// No dependencies; imported by edm_decide and edge_debounce_monitor.
`timescale 1ns / 1ps

package edm_pkg;

  // Result codes carried on the master-side tuser.
  typedef enum logic [2:0] {
    RES_QUERY       = 3'd0,
    RES_BOUNCE_SOON = 3'd1,
    RES_BOUNCE_SAME = 3'd2,
    RES_CHANGE      = 3'd3,
    RES_READ_FAIL   = 3'd4
  } result_e;

  // Held switch state.
  typedef enum logic [1:0] {
    SW_CLOSED  = 2'd0,
    SW_OPEN    = 2'd1,
    SW_UNKNOWN = 2'd2
  } door_e;

  // Item kind carried on the slave-side tuser.
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int WINDOW_BITS = 16;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd50;

  // State updates decided for one beat.
  typedef struct packed {
    logic accept_time;  // record now as the last accepted edge time
    logic change;       // take the new level, change time and count
    logic bounce;       // bump the bounce counter
  } upd_t;

endpackage

// ===== design/edm_decide.sv =====
// Per-beat debounce decision: window check, level compare, result code.
// Depends on edm_pkg.
`timescale 1ns / 1ps

module edm_decide #(
  parameter int TIME_BITS = 32
) (
  input  logic                              mode_i,
  input  logic [TIME_BITS-1:0]              now_i,
  input  logic                              level_i,
  input  logic                              failed_i,
  input  logic [edm_pkg::WINDOW_BITS-1:0]   window_i,
  input  edm_pkg::door_e                    door_i,
  input  logic [TIME_BITS-1:0]              last_accept_i,
  input  logic [TIME_BITS-1:0]              last_change_i,
  output edm_pkg::result_e                  code_o,
  output edm_pkg::upd_t                     upd_o,
  output logic [TIME_BITS-1:0]              held_o
);
  import edm_pkg::*;

  logic [TIME_BITS-1:0] since;
  logic                 too_soon;
  logic                 same_level;

  assign since      = now_i - last_accept_i;
  assign held_o     = now_i - last_change_i;
  assign too_soon   = 64'(since) < 64'(window_i);
  assign same_level = {1'b0, level_i} == door_i;

  always_comb begin
    code_o = RES_QUERY;
    upd_o  = '0;
    if (mode_i == MODE_EDGE) begin
      if (too_soon) begin
        code_o       = RES_BOUNCE_SOON;
        upd_o.bounce = 1'b1;
      end else begin
        upd_o.accept_time = 1'b1;
        if (failed_i) begin
          code_o = RES_READ_FAIL;
        end else if (same_level) begin
          code_o       = RES_BOUNCE_SAME;
          upd_o.bounce = 1'b1;
        end else begin
          code_o       = RES_CHANGE;
          upd_o.change = 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/edge_debounce_monitor.sv =====
// Top level of the edge debounce monitor: stream ports, state and counters.
// Depends on edm_pkg and edm_decide.
`timescale 1ns / 1ps

// Lockout-window debounce for a two-level switch line. Each slave beat is an
// edge event (tuser 0) or a status query (tuser 1) stamped with a wrapping
// millisecond time; each produces exactly one master beat with a result code
// on tuser and the held state, change count, bounce count and the time since
// the previous change on tdata. An edge closer than debounce_window_ms to the
// last accepted edge is a bounce; otherwise its time is recorded, a failed
// read is dropped, a level equal to the held state is a bounce and any other
// level is a change. The held state starts unknown, so the first good edge
// past the window is always a change. Throughput is one beat per cycle while
// m_axis_tready is high: a beat lands in an input register, the decision is
// two subtracts, two compares and the counter increments, and the result is
// registered in the output register, which drives tvalid. The input register
// frees as soon as its beat moves on, so a new beat is taken while a result
// still waits on m_axis_tready. Write the window through cfg_we_i/cfg_wdata_i
// only while the block is idle.
module edge_debounce_monitor #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config: lockout window in ms
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // now_ms[31:0], line_level[32], read_failed[33], 0
  input  logic [0:0]   s_axis_tuser,   // mode[0]
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // door_status[1:0], changes_seen[33:2],
                                       // bounces_seen[65:34], held_ms[97:66], 0
  output logic [2:0]   m_axis_tuser    // result_code[2:0]
);
  import edm_pkg::*;

  // Configuration register.
  logic [WINDOW_BITS-1:0] window_q;

  // Input register.
  logic        in_valid_q;
  logic        mode_q;
  logic [31:0] now_q;
  logic        level_q;
  logic        failed_q;

  // Block state.
  door_e                 door_q;
  logic [TIME_BITS-1:0]  accept_time_q;
  logic [TIME_BITS-1:0]  change_time_q;
  logic [COUNT_BITS-1:0] chg_cnt_q;
  logic [COUNT_BITS-1:0] bnc_cnt_q;

  // Output register (counts and state are read straight from the state,
  // which cannot move while a result is pending).
  logic                 out_valid_q;
  result_e              code_q;
  logic [31:0]          held_q;

  logic                 advance;
  logic [TIME_BITS-1:0] now_t;
  result_e              code;
  upd_t                 upd;
  logic [TIME_BITS-1:0] held;
  logic [63:0]          now_ext;
  logic [63:0]          held_ext;
  logic [63:0]          chg_ext;
  logic [63:0]          bnc_ext;

  // Move the input beat to the output register when the output is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign now_ext = 64'(now_q);
  assign now_t   = now_ext[TIME_BITS-1:0];

  edm_decide #(
    .TIME_BITS(TIME_BITS)
  ) u_decide (
    .mode_i       (mode_q),
    .now_i        (now_t),
    .level_i      (level_q),
    .failed_i     (failed_q),
    .window_i     (window_q),
    .door_i       (door_q),
    .last_accept_i(accept_time_q),
    .last_change_i(change_time_q),
    .code_o       (code),
    .upd_o        (upd),
    .held_o       (held)
  );

  assign held_ext = 64'(held);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // Input register: valid under reset, payload loads on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q   <= s_axis_tuser[0];
      now_q    <= s_axis_tdata[31:0];
      level_q  <= s_axis_tdata[32];
      failed_q <= s_axis_tdata[33];
    end
  end

  // State update for the beat that advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q        <= SW_UNKNOWN;
      accept_time_q <= '0;
      change_time_q <= '0;
      chg_cnt_q     <= '0;
      bnc_cnt_q     <= '0;
    end else if (advance) begin
      if (upd.accept_time) begin
        accept_time_q <= now_t;
      end
      if (upd.change) begin
        door_q        <= level_q ? SW_OPEN : SW_CLOSED;
        change_time_q <= now_t;
        chg_cnt_q     <= chg_cnt_q + 1'b1;
      end
      if (upd.bounce) begin
        bnc_cnt_q <= bnc_cnt_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code;
      held_q <= held_ext[31:0];
    end
  end

  assign chg_ext = 64'(chg_cnt_q);
  assign bnc_ext = 64'(bnc_cnt_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = code_q;
  assign m_axis_tdata  = {6'd0, held_q, bnc_ext[31:0], chg_ext[31:0], door_q};

  // A change bumps the change counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && code == RES_CHANGE |=> chg_cnt_q == $past(chg_cnt_q) + 1'b1)
    else $error("change count did not advance on a change");

  // Bounce results bump the bounce counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (code == RES_BOUNCE_SOON || code == RES_BOUNCE_SAME)
    |=> bnc_cnt_q == $past(bnc_cnt_q) + 1'b1)
    else $error("bounce count did not advance on a bounce");

  // A query leaves all state untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && code == RES_QUERY
    |=> $stable(door_q) && $stable(chg_cnt_q) && $stable(bnc_cnt_q)
        && $stable(accept_time_q) && $stable(change_time_q))
    else $error("query changed state");

  // The slave side stalls only when both registers are full and the master stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("slave side stalled without a full pipeline");

endmodule

// ===== tb/tb_edge_debounce_monitor.sv =====
// Self-checking testbench for edge_debounce_monitor: directed and random beats,
// a behavioral predictor of the debounce decision, and a per-field result check.
// Depends on edm_pkg and the edge_debounce_monitor RTL.
`timescale 1ns / 1ps

module tb_edge_debounce_monitor;
  import edm_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;       // idle margin after the last result

  // One predicted master beat.
  typedef struct packed {
    result_e     code;
    door_e       door;
    logic [31:0] changes;
    logic [31:0] bounces;
    logic [31:0] held;
  } verdict_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [15:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata  = '0;   // now_ms[31:0], line_level[32], read_failed[33], 0
  logic [0:0]   s_axis_tuser  = '0;   // mode[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;         // door_status[1:0], changes_seen[33:2],
                                      // bounces_seen[65:34], held_ms[97:66], 0
  logic [2:0]   m_axis_tuser;         // result_code[2:0]

  // Predictor state, mirrors the block's registers.
  logic [15:0]  window_ms_q = 16'd50;
  door_e        door_q      = SW_UNKNOWN;
  logic [31:0]  accept_ms   = '0;
  logic [31:0]  change_ms   = '0;
  logic [31:0]  change_cnt  = '0;
  logic [31:0]  bounce_cnt  = '0;

  verdict_t     verdicts_due[$];
  int           mismatches  = 0;
  int           cycles      = 0;
  bit           idle_on     = 1'b1;
  int           stall_left  = 0;
  logic [31:0]  clock_ms    = '0;

  edge_debounce_monitor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Debounce decision for one accepted beat. Updates the predictor state and
  // returns what the block must report. Elapsed times wrap at 32 bits and
  // compare unsigned against the window.
  function automatic verdict_t debounce_verdict(input logic mode, input logic [31:0] now,
                                                input logic level, input logic failed);
    verdict_t    v;
    logic [31:0] since;
    v.held = now - change_ms;   // taken before any update by this beat
    if (mode == MODE_QUERY) begin
      v.code = RES_QUERY;
    end else begin
      since = now - accept_ms;
      if (since < {16'd0, window_ms_q}) begin
        bounce_cnt = bounce_cnt + 1;
        v.code     = RES_BOUNCE_SOON;
      end else begin
        accept_ms = now;
        if (failed) begin
          v.code = RES_READ_FAIL;   // edge time still taken, counters hold
        end else if (door_e'({1'b0, level}) == door_q) begin
          bounce_cnt = bounce_cnt + 1;
          v.code     = RES_BOUNCE_SAME;
        end else begin
          door_q     = door_e'({1'b0, level});
          change_ms  = now;
          change_cnt = change_cnt + 1;
          v.code     = RES_CHANGE;
        end
      end
    end
    v.door    = door_q;
    v.changes = change_cnt;
    v.bounces = bounce_cnt;
    return v;
  endfunction

  // Drive one slave beat and hold it until accepted. Leaves tvalid high so a
  // following beat goes out back to back; callers drop it when done.
  task automatic send_beat(input logic mode, input logic [31:0] now,
                           input logic level, input logic failed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, failed, level, now};
    do @(posedge clk_i); while (!s_axis_tready);
    verdicts_due.push_back(debounce_verdict(mode, now, level, failed));
  endtask

  // Drop tvalid and wait until every result is out, then wait out the SETTLE margin.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the lockout window while the block is idle.
  task automatic set_window(input logic [15:0] w);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_ms_q = w;
  endtask

  // Receiver side: while idle_on is set, hold tready low in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted master beat against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    verdict_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.code    = result_e'(m_axis_tuser);
      got.door    = door_e'(m_axis_tdata[1:0]);
      got.changes = m_axis_tdata[33:2];
      got.bounces = m_axis_tdata[65:34];
      got.held    = m_axis_tdata[97:66];
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: code %0d door %0d",
                   $realtime, got.code, got.door);
      end else begin
        want = verdicts_due.pop_front();
        if (got.code !== want.code || got.door !== want.door ||
            got.changes !== want.changes || got.bounces !== want.bounces ||
            got.held !== want.held) begin
          mismatches++;
          // fields in order: code, door, changes, bounces, held
          if (mismatches <= 10)
            $display("%0t: exp %0d/%0d/%0d/%0d/%0d act %0d/%0d/%0d/%0d/%0d",
                     $realtime, want.code, want.door, want.changes, want.bounces,
                     want.held, got.code, got.door, got.changes, got.bounces, got.held);
        end
      end
    end
  end

  // State starts unknown and the accepted-edge time at zero: an early edge is
  // a bounce, the first good edge past the window is a change, a failed read
  // still moves the accepted-edge time, and a query ignores level and failure.
  task automatic test_power_up;
    send_beat(MODE_QUERY, 32'd0,   1'b1, 1'b1);
    send_beat(MODE_EDGE,  32'd10,  1'b1, 1'b0);
    send_beat(MODE_EDGE,  32'd50,  1'b0, 1'b0);
    send_beat(MODE_EDGE,  32'd60,  1'b1, 1'b0);
    send_beat(MODE_EDGE,  32'd100, 1'b1, 1'b1);
    send_beat(MODE_EDGE,  32'd120, 1'b1, 1'b0);
    send_beat(MODE_EDGE,  32'd150, 1'b0, 1'b0);
    send_beat(MODE_EDGE,  32'd200, 1'b1, 1'b0);
    send_beat(MODE_QUERY, 32'hFFFF_FFFF, 1'b0, 1'b0);
  endtask

  // Timestamps crossing the 32-bit wrap, both for the window and for held_ms.
  task automatic test_wrapping_time;
    send_beat(MODE_EDGE,  32'hFFFF_FFF0, 1'b0, 1'b0);
    send_beat(MODE_EDGE,  32'h0000_0010, 1'b1, 1'b0);
    send_beat(MODE_EDGE,  32'h0000_0030, 1'b1, 1'b0);
    send_beat(MODE_QUERY, 32'h0000_0005, 1'b1, 1'b0);
  endtask

  // Window of zero passes every edge; the widest window is checked one short
  // of and exactly at its length.
  task automatic test_window_extremes;
    set_window(16'd0);
    send_beat(MODE_EDGE, 32'd1000, 1'b1, 1'b0);
    send_beat(MODE_EDGE, 32'd1000, 1'b0, 1'b0);
    send_beat(MODE_EDGE, 32'd1000, 1'b0, 1'b0);
    set_window(16'hFFFF);
    send_beat(MODE_EDGE, 32'd1000 + 32'd65534, 1'b1, 1'b0);
    send_beat(MODE_EDGE, 32'd1000 + 32'd65535, 1'b1, 1'b0);
    send_beat(MODE_EDGE, 32'd1000 + 32'd65535, 1'b0, 1'b1);
  endtask

  // Random beats near the window scale so both outcomes of the lockout test
  // occur, with an occasional jump anywhere in time. Returns with tvalid held.
  task automatic random_beats(input int n);
    int unsigned span;
    span = 2 * window_ms_q + 8;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else                            clock_ms = clock_ms + $urandom_range(0, span);
      send_beat(($urandom_range(0, 5) == 0) ? MODE_QUERY : MODE_EDGE, clock_ms,
                1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    end
  endtask

  // Chunks of random traffic, each under a new window, idling switched per chunk.
  task automatic test_random_traffic;
    logic [15:0] w;
    clock_ms = $urandom;
    repeat (8) begin
      case ($urandom_range(0, 5))
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        2:       w = 16'd1;
        5:       w = 16'($urandom);
        default: w = 16'($urandom_range(2, 200));
      endcase
      set_window(w);
      idle_on = ($urandom_range(0, 3) != 0);
      random_beats(50);
    end
  endtask

  // Closing stretch at full rate on both sides with the reset window.
  task automatic test_back_to_back;
    set_window(16'd50);
    idle_on = 1'b0;
    random_beats(50);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up();
    test_wrapping_time();
    test_window_extremes();
    test_random_traffic();
    test_back_to_back();
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
